/* rtl/core/stbs_pkg.sv */
// shared types and constants for the sorted record table
// no dependencies; used by stbs_store and sort_then_binary_search_table
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // default table depth
  localparam int unsigned DEFAULT_DEPTH = 64;

  // field widths
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned POS_W = 6;

  // item codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_FOUND   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } record_t;

endpackage

`default_nettype wire

/* rtl/core/stbs_store.sv */
// record store: one write port, one read port with registered read data
// depends on stbs_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module stbs_store #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire stbs_pkg::record_t wr_rec,
  input  wire logic [IW-1:0]    rd_addr,
  output stbs_pkg::record_t     rd_rec
);

  stbs_pkg::record_t mem [TABLE_DEPTH];
  stbs_pkg::record_t rd_rec_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_rec_r <= mem[rd_addr];
  end

  assign rd_rec = rd_rec_r;

endmodule

`default_nettype wire

/* rtl/core/sort_then_binary_search_table.sv */
// Sorted record table with binary search.
// Command channel: an item (in_func, in_key, in_payload, in_last_record) is
// taken at a rising edge where start is high and busy is low. Each item gives
// exactly one result word on the out_ ports, shown for one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// A load word is stored at the next free table entry and answered in the cycle
// after it is taken; loads can follow each other in every cycle while busy is low. A load word
// with in_last_record set closes the set; the table is then bubble sorted in
// descending key order (equal keys keep load order) while busy is high.
// Each sort pass is one read sweep over the remaining span, one entry at a
// time through the single read and single write port of the store, and
// passes stop early when nothing moved.
// A search word runs a binary search over the sorted table: one store read
// and one compare per probe, in states S_SRCH_RD and S_SRCH_CMP; busy stays
// high until the result is given.
// A load after the set is closed starts a new set. Loads beyond the depth
// are dropped with status dropped. A search on an open or empty set answers
// not found at once.
// Reset (synchronous, active low) empties the set and returns to idle; the
// store contents are not cleared and are only read after being written.
`timescale 1ns / 1ps
`default_nettype none

module sort_then_binary_search_table #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_func,
  input  wire logic [stbs_pkg::KEY_W-1:0] in_key,
  input  wire logic [stbs_pkg::PAY_W-1:0] in_payload,
  input  wire logic                       in_last_record,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [stbs_pkg::POS_W-1:0]      out_position,
  output logic [stbs_pkg::KEY_W-1:0]      out_found_key,
  output logic [stbs_pkg::PAY_W-1:0]      out_found_payload
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = (IW > stbs_pkg::POS_W) ? IW : stbs_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_START,
    S_SORT_FIRST,
    S_SORT_SWEEP,
    S_SORT_TAIL,
    S_SRCH_RD,
    S_SRCH_CMP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         closed_r, closed_nxt;
  logic [CW-1:0]                span_r, span_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  stbs_pkg::record_t            carry_r, carry_nxt;
  logic                         swapped_r, swapped_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hiex_r, hiex_nxt;
  logic [IW-1:0]                mid_r, mid_nxt;
  logic [stbs_pkg::KEY_W-1:0]   skey_r, skey_nxt;
  logic                         out_valid_r, out_valid_nxt;
  stbs_pkg::status_t            out_status_r, out_status_nxt;
  logic [stbs_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [stbs_pkg::KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [stbs_pkg::PAY_W-1:0]   out_pay_r, out_pay_nxt;

  // store port signals
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  stbs_pkg::record_t            wr_rec;
  logic [IW-1:0]                rd_addr;
  stbs_pkg::record_t            rd_rec;

  // helpers
  logic [CW-1:0]                ld_base;
  logic                         ld_fits;
  logic [CW-1:0]                ld_cnt;
  logic [CW:0]                  mid_sum;
  logic [IW-1:0]                mid_calc;
  logic [CW-1:0]                lo_new;
  logic [CW-1:0]                hiex_new;
  logic                         carry_lt;
  logic [PW-1:0]                pos_ext;

  stbs_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  // load slot: a closed set restarts from zero
  assign ld_base = closed_r ? '0 : cnt_r;
  assign ld_fits = ld_base < DEPTH_C;
  assign ld_cnt  = ld_fits ? ld_base + CW'(1) : ld_base;

  // binary search midpoint over [lo, hiex)
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hiex_r} - (CW+1)'(1);
  assign mid_calc = mid_sum[IW:1];

  // search window after a miss at mid
  assign hiex_new = (skey_r > rd_rec.key) ? CW'(mid_r) : hiex_r;
  assign lo_new   = (skey_r > rd_rec.key) ? lo_r : CW'(mid_r) + CW'(1);

  // sweep compare: the carried record moves toward the tail while smaller
  assign carry_lt = carry_r.key < rd_rec.key;

  assign pos_ext = PW'(mid_r);

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    closed_nxt     = closed_r;
    span_nxt       = span_r;
    idx_nxt        = idx_r;
    carry_nxt      = carry_r;
    swapped_nxt    = swapped_r;
    lo_nxt         = lo_r;
    hiex_nxt       = hiex_r;
    mid_nxt        = mid_r;
    skey_nxt       = skey_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_rec         = carry_r;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_pos_nxt = '0;
          out_key_nxt = '0;
          out_pay_nxt = '0;
          if (in_func == stbs_pkg::FUNC_LOAD) begin
            out_valid_nxt = 1'b1;
            cnt_nxt       = ld_cnt;
            closed_nxt    = in_last_record;
            if (ld_fits) begin
              wr_en          = 1'b1;
              wr_addr        = ld_base[IW-1:0];
              wr_rec.key     = in_key;
              wr_rec.payload = in_payload;
              out_status_nxt = stbs_pkg::ST_LOADED;
            end else begin
              out_status_nxt = stbs_pkg::ST_DROPPED;
            end
            if (in_last_record) begin
              span_nxt  = ld_cnt;
              state_nxt = S_SORT_START;
            end
          end else begin
            skey_nxt = in_key;
            if (closed_r && (cnt_r != '0)) begin
              lo_nxt    = '0;
              hiex_nxt  = cnt_r;
              state_nxt = S_SRCH_RD;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = stbs_pkg::ST_MISSING;
            end
          end
        end
      end

      // start a pass by reading the head entry; a span of one entry or less ends the sort
      S_SORT_START: begin
        if (span_r <= CW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr   = '0;
          state_nxt = S_SORT_FIRST;
        end
      end

      // head entry becomes the carried record
      S_SORT_FIRST: begin
        carry_nxt   = rd_rec;
        rd_addr     = IW'(1);
        idx_nxt     = IW'(1);
        swapped_nxt = 1'b0;
        state_nxt   = S_SORT_SWEEP;
      end

      // one compare per entry, the larger one lands one slot back
      S_SORT_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - IW'(1);
        if (carry_lt) begin
          wr_rec      = rd_rec;
          swapped_nxt = 1'b1;
        end else begin
          wr_rec    = carry_r;
          carry_nxt = rd_rec;
        end
        if ((CW'(idx_r) + CW'(1)) < span_r) begin
          rd_addr = idx_r + IW'(1);
          idx_nxt = idx_r + IW'(1);
        end else begin
          state_nxt = S_SORT_TAIL;
        end
      end

      // carried record lands at the end of the span
      S_SORT_TAIL: begin
        wr_en    = 1'b1;
        wr_addr  = idx_r;
        wr_rec   = carry_r;
        span_nxt = span_r - CW'(1);
        if (swapped_r && ((span_r - CW'(1)) > CW'(1))) begin
          state_nxt = S_SORT_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // probe the midpoint
      S_SRCH_RD: begin
        rd_addr   = mid_calc;
        mid_nxt   = mid_calc;
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (rd_rec.key == skey_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stbs_pkg::ST_FOUND;
          out_pos_nxt    = pos_ext[stbs_pkg::POS_W-1:0];
          out_key_nxt    = rd_rec.key;
          out_pay_nxt    = rd_rec.payload;
          state_nxt      = S_IDLE;
        end else begin
          lo_nxt   = lo_new;
          hiex_nxt = hiex_new;
          if (lo_new < hiex_new) begin
            state_nxt = S_SRCH_RD;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = stbs_pkg::ST_MISSING;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    span_r       <= span_nxt;
    idx_r        <= idx_nxt;
    carry_r      <= carry_nxt;
    swapped_r    <= swapped_nxt;
    lo_r         <= lo_nxt;
    hiex_r       <= hiex_nxt;
    mid_r        <= mid_nxt;
    skey_r       <= skey_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
  end

  // port drive
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_position      = out_pos_r;
  assign out_found_key     = out_key_r;
  assign out_found_payload = out_pay_r;

endmodule

`default_nettype wire
